/* rtl/core/hdlp_pkg.sv */
package hdlp_pkg;

  // Default sizes of one dump line.
  localparam int unsigned DefRowBytes   = 8;
  localparam int unsigned DefAddrDigits = 4;

  // Fixed field widths.
  localparam int unsigned CharW    = 8;
  localparam int unsigned NibW     = 4;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned RowW     = 64;
  localparam int unsigned CountW   = 4;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned OutDataW = 88;

  // Character codes the parser reacts to.
  localparam logic [CharW-1:0] CharColon  = 8'h3A;
  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharNine   = 8'h39;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerF = 8'h66;
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperF = 8'h46;
  localparam logic [CharW-1:0] DigitTen   = 8'd10;

  // Line status codes.
  typedef enum logic [StatusW-1:0] {
    StOk         = 3'd0,
    StNoColon    = 3'd1,
    StTooMany    = 3'd2,
    StEarlyColon = 3'd3,
    StExtraColon = 3'd4
  } status_e;

  // Classification of one character.
  typedef struct packed {
    logic            is_hex;
    logic            is_colon;
    logic [NibW-1:0] nib;
  } char_class_t;

endpackage

/* rtl/core/hdlp_char_decode.sv */
module hdlp_char_decode (
  input  logic [hdlp_pkg::CharW-1:0] char_i,
  output hdlp_pkg::char_class_t      class_o
);

  logic                       is_dec;
  logic                       is_lower;
  logic                       is_upper;
  logic [hdlp_pkg::CharW-1:0] offset;

  // Range checks for the three digit groups, case-insensitive.
  assign is_dec   = (char_i >= hdlp_pkg::CharZero)   && (char_i <= hdlp_pkg::CharNine);
  assign is_lower = (char_i >= hdlp_pkg::CharLowerA) && (char_i <= hdlp_pkg::CharLowerF);
  assign is_upper = (char_i >= hdlp_pkg::CharUpperA) && (char_i <= hdlp_pkg::CharUpperF);

  // Digit value from the start of its group, plus ten for letters.
  always_comb begin
    if (is_lower) begin
      offset = char_i - hdlp_pkg::CharLowerA + hdlp_pkg::DigitTen;
    end else if (is_upper) begin
      offset = char_i - hdlp_pkg::CharUpperA + hdlp_pkg::DigitTen;
    end else begin
      offset = char_i - hdlp_pkg::CharZero;
    end
  end

  assign class_o.is_hex   = is_dec || is_lower || is_upper;
  assign class_o.is_colon = (char_i == hdlp_pkg::CharColon);
  assign class_o.nib      = offset[hdlp_pkg::NibW-1:0];

endmodule

/* rtl/core/hex_dump_line_parser.sv */
// Hex dump line parser.
// The input stream carries one text character per item in s_axis_tdata, with
// s_axis_tlast marking the last character of a line. Lines look like
// "AAAA: bb bb ...": the leading digits form the address, a colon follows,
// and later digit pairs fill a row of up to ROW_BYTES bytes. Other characters
// are skipped. The output stream gives one item per line end, or one item
// with a nonzero status on a format error, after which all input is taken
// and dropped until reset.
// A result passes through the input register and then the result register
// before it leaves. Throughput: one character per cycle while the result
// register can take a result; the line state is updated in one step from
// the input register, so the line-state update loop sets the rate.
// When the receiver stalls with a result waiting, characters that are already
// registered wait and s_axis_tready drops after the input register fills.
// Reset clears the line state, the halt flag and both valid flags.
module hex_dump_line_parser #(
  parameter int unsigned ROW_BYTES   = hdlp_pkg::DefRowBytes,
  parameter int unsigned ADDR_DIGITS = hdlp_pkg::DefAddrDigits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // char_code [7:0]
  input  logic [hdlp_pkg::CharW-1:0]    s_axis_tdata,
  // line_end
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // row_data [63:0], line_address [79:64], bytes_filled [83:80],
  // status [86:84], zero [87]
  output logic [hdlp_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned RowStoreW = ROW_BYTES * 8;
  localparam int unsigned DigW      = $clog2(ADDR_DIGITS + 1);

  // Input register.
  logic                       in_valid_q, in_valid_d;
  logic [hdlp_pkg::CharW-1:0] in_char_q;
  logic                       in_last_q;
  logic                       advance;

  // Line state.
  logic [hdlp_pkg::AddrW-1:0]  addr_q, addr_d, addr_upd;
  logic [DigW-1:0]             digits_q, digits_d, digits_upd;
  logic                        colon_q, colon_d, colon_upd;
  logic [hdlp_pkg::NibW-1:0]   pend_q, pend_d, pend_upd;
  logic                        held_q, held_d, held_upd;
  logic [hdlp_pkg::CountW-1:0] index_q, index_d, index_upd;
  logic [RowStoreW-1:0]        row_q, row_d, row_upd;
  logic                        halted_q, halted_d;

  // Result register.
  logic                          out_valid_q, out_valid_d;
  logic [hdlp_pkg::OutDataW-1:0] out_data_q, out_data_d;

  hdlp_pkg::char_class_t cls;
  hdlp_pkg::status_e     err;
  logic                  emit;
  logic                  addr_done;

  hdlp_char_decode u_decode (
    .char_i  (in_char_q),
    .class_o (cls)
  );

  // The registered item moves on when the result register can take a result.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !advance);
  assign addr_done     = (digits_q >= DigW'(ADDR_DIGITS));

  // Per-character line state update and result formation.
  always_comb begin
    addr_upd   = addr_q;
    digits_upd = digits_q;
    colon_upd  = colon_q;
    pend_upd   = pend_q;
    held_upd   = held_q;
    index_upd  = index_q;
    row_upd    = row_q;
    err        = hdlp_pkg::StOk;
    emit       = 1'b0;
    halted_d   = halted_q;

    if (cls.is_hex) begin
      if (addr_done && !colon_q) begin
        err = hdlp_pkg::StNoColon;
      end else if (!addr_done) begin
        addr_upd   = {addr_q[hdlp_pkg::AddrW-hdlp_pkg::NibW-1:0], cls.nib};
        digits_upd = digits_q + DigW'(1);
      end else if (index_q >= hdlp_pkg::CountW'(ROW_BYTES)) begin
        err = hdlp_pkg::StTooMany;
      end else if (!held_q) begin
        pend_upd = cls.nib;
        held_upd = 1'b1;
      end else begin
        for (int k = 0; k < ROW_BYTES; k++) begin
          if (index_q == hdlp_pkg::CountW'(k)) begin
            row_upd[k*8 +: 8] = {pend_q, cls.nib};
          end
        end
        index_upd = index_q + hdlp_pkg::CountW'(1);
        pend_upd  = '0;
        held_upd  = 1'b0;
      end
    end else if (cls.is_colon) begin
      if (!addr_done) begin
        err = hdlp_pkg::StEarlyColon;
      end else if (colon_q) begin
        err = hdlp_pkg::StExtraColon;
      end else begin
        colon_upd = 1'b1;
      end
    end

    addr_d   = addr_upd;
    digits_d = digits_upd;
    colon_d  = colon_upd;
    pend_d   = pend_upd;
    held_d   = held_upd;
    index_d  = index_upd;
    row_d    = row_upd;

    if (halted_q) begin
      emit = 1'b0;
    end else if (err != hdlp_pkg::StOk) begin
      emit     = 1'b1;
      halted_d = 1'b1;
    end else if (in_last_q) begin
      emit     = 1'b1;
      addr_d   = '0;
      digits_d = '0;
      colon_d  = 1'b0;
      pend_d   = '0;
      held_d   = 1'b0;
      index_d  = '0;
      row_d    = '0;
    end

    out_data_d = {1'b0, err, index_upd, addr_upd, hdlp_pkg::RowW'(row_upd)};
  end

  assign out_valid_d = advance ? emit : (out_valid_q && !m_axis_tready);

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      halted_q    <= 1'b0;
      addr_q      <= '0;
      digits_q    <= '0;
      colon_q     <= 1'b0;
      pend_q      <= '0;
      held_q      <= 1'b0;
      index_q     <= '0;
      row_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance && !halted_q) begin
        halted_q <= halted_d;
        addr_q   <= addr_d;
        digits_q <= digits_d;
        colon_q  <= colon_d;
        pend_q   <= pend_d;
        held_q   <= held_d;
        index_q  <= index_d;
        row_q    <= row_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
